@@ rtl/lph_pkg.sv @@
// Package: shared types and status codes for the linear probe hash table.
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lph_entry_t;

endpackage
`default_nettype wire

@@ rtl/lph_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lph_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/lph_mod.sv @@
// Home slot unit: key modulo the table size, a mask for powers of two,
// otherwise a reciprocal multiply and a multiply-subtract on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module lph_mod #(
  parameter int TABLE_SLOTS = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [lph_pkg::KEY_W-1:0]      key,
  output logic                                done,
  output logic [$clog2(TABLE_SLOTS)-1:0]      rem
);

  localparam int IDXW = $clog2(TABLE_SLOTS);

  generate
    if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
      logic            done_r;
      logic [IDXW-1:0] rem_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_r <= key[IDXW-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end else begin : g_div
      // ceil(2^SHIFT / TABLE_SLOTS): key * RECIP >> SHIFT is the exact quotient
      // for every 31-bit key, and RECIP fits in 32 bits
      localparam int          SHIFT = lph_pkg::KEY_W + IDXW;
      localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(TABLE_SLOTS - 1)) / 64'(TABLE_SLOTS);

      logic                      busy_r;
      logic                      step_r;
      logic                      done_r;
      logic [lph_pkg::KEY_W-1:0] key_r;
      logic [63:0]               prod_r;
      logic [31:0]               mul_a;
      logic [31:0]               mul_b;
      logic [63:0]               mul_p;

      // first pass: key * RECIP; second pass: quotient * TABLE_SLOTS
      always_comb begin
        if (!step_r) begin
          mul_a = {1'b0, key_r};
          mul_b = RECIP[31:0];
        end else begin
          mul_a = 32'(prod_r >> SHIFT);
          mul_b = 32'(TABLE_SLOTS);
        end
        mul_p = mul_a * mul_b;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          step_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          done_r <= busy_r && step_r;
          if (start) begin
            busy_r <= 1'b1;
            step_r <= 1'b0;
          end else if (busy_r) begin
            busy_r <= !step_r;
            step_r <= !step_r;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          key_r <= key;
        end else if (busy_r) begin
          prod_r <= mul_p;
        end
      end

      // the remainder is below TABLE_SLOTS, so the low bits of the difference suffice
      assign done = done_r;
      assign rem  = key_r[IDXW-1:0] - prod_r[IDXW-1:0];
    end
  endgenerate

endmodule
`default_nettype wire

@@ rtl/linear_probe_hash_table_unit.sv @@
// Top level: open-addressing key/value table with linear probing.
//
//  channel | direction | ports                                   | handshake
//  in      | input     | in_req_type, in_req_key, in_req_value   | in_valid / in_stall
//  out     | output    | out_status, out_found_value             | out_valid / out_stall
//
// After reset a clearing pass writes every slot empty, with in_stall high.
// An item is accepted, its home slot is computed (a mask for a power-of-two table,
// a reciprocal multiply and a multiply-subtract otherwise), its slots are probed in
// turn from the home slot, and the result is posted to the output register.
// The slot RAM's single read port sets the probe rate at one slot per cycle.
// A waiting result does not block the next item; a stalled output holds the
// finished item inside until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table_unit #(
  parameter int TABLE_SLOTS = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_req_type,
  input  wire logic [lph_pkg::KEY_W-1:0]        in_req_key,
  input  wire logic signed [lph_pkg::VAL_W-1:0] in_req_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [lph_pkg::ST_W-1:0]              out_status,
  output logic signed [lph_pkg::VAL_W-1:0]      out_found_value
);

  localparam int IDXW    = $clog2(TABLE_SLOTS);
  localparam int ENTRY_W = $bits(lph_pkg::lph_entry_t);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SLOTS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HOME  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [IDXW-1:0]           idx_r, idx_nxt;
  logic [IDXW-1:0]           cnt_r, cnt_nxt;
  logic                      type_r;
  logic [lph_pkg::KEY_W-1:0] key_r;
  logic [lph_pkg::VAL_W-1:0] value_r;
  logic [lph_pkg::ST_W-1:0]  res_status_r, res_status_nxt;
  logic [lph_pkg::VAL_W-1:0] res_value_r, res_value_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [lph_pkg::ST_W-1:0]  out_status_r;
  logic [lph_pkg::VAL_W-1:0] out_value_r;

  logic                      in_accept;
  logic                      out_load;
  logic                      mod_done;
  logic [IDXW-1:0]           mod_rem;
  logic [IDXW-1:0]           idx_inc;
  logic                      ram_we;
  logic [IDXW-1:0]           ram_waddr;
  lph_pkg::lph_entry_t       ram_wentry;
  logic [IDXW-1:0]           ram_raddr;
  logic [ENTRY_W-1:0]        ram_rdata;
  lph_pkg::lph_entry_t       rd_entry;
  logic                      hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign idx_inc   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign rd_entry  = lph_pkg::lph_entry_t'(ram_rdata);
  assign hit       = !rd_entry.used || (rd_entry.key == key_r);

  // in CHECK the next slot is read ahead, so its entry is ready when the current slot misses
  assign ram_raddr = (state_r == S_CHECK) ? idx_inc : mod_rem;

  lph_mod #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(in_accept),
    .key  (in_req_key),
    .done (mod_done),
    .rem  (mod_rem)
  );

  lph_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ENTRY_W'(ram_wentry)),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wentry     = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        if (mod_done) begin
          idx_nxt   = mod_rem;
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          res_value_nxt = '0;
          if (type_r == lph_pkg::REQ_INSERT) begin
            ram_we           = 1'b1;
            ram_wentry.used  = 1'b1;
            ram_wentry.key   = key_r;
            ram_wentry.value = value_r;
            res_status_nxt   = lph_pkg::ST_OK;
          end else if (rd_entry.used) begin
            res_status_nxt = lph_pkg::ST_OK;
            res_value_nxt  = rd_entry.value;
          end else begin
            res_status_nxt = lph_pkg::ST_NOT_FOUND;
          end
          state_nxt = S_DONE;
        end else if (cnt_r == LAST_IDX) begin
          // a full lap without a match or an empty slot
          res_status_nxt = lph_pkg::ST_FULL;
          res_value_nxt  = '0;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (in_accept) begin
      type_r  <= in_req_type;
      key_r   <= in_req_key;
      value_r <= in_req_value;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

endmodule
`default_nettype wire

@@ rtl/lph_chk.sv @@
// Port checker for the linear probe hash table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lph_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [lph_pkg::ST_W-1:0]         out_status,
  input wire logic signed [lph_pkg::VAL_W-1:0] out_found_value
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found_value))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == lph_pkg::ST_OK || out_status == lph_pkg::ST_NOT_FOUND ||
                   out_status == lph_pkg::ST_FULL))
    else $error("bad status code");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lph_pkg::ST_OK |-> out_found_value == '0)
    else $error("nonzero value on miss or full");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("outputs active after reset");

endmodule

bind linear_probe_hash_table_unit lph_chk u_lph_chk (.*);
`default_nettype wire

@@ tb/tb_linear_probe_hash_table_unit.sv @@
// Testbench: random and directed lookup/insert traffic against a self-checking table predictor.
`timescale 1ns / 1ps
module tb_linear_probe_hash_table_unit;
  import lph_pkg::*;

  localparam int TABLE_SLOTS = 128;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
  } reply_t;

  // Shadow copy of the table plus the replies still owed by the block.
  class lph_scoreboard #(int SLOTS = 128);
    logic                        slot_used [SLOTS];
    logic [lph_pkg::KEY_W-1:0]   slot_key  [SLOTS];
    logic [lph_pkg::VAL_W-1:0]   slot_value[SLOTS];
    reply_t                      replies_due[$];
    int n_inserts, n_lookups, n_ok, n_not_found, n_full, n_errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void report_error(string what);
      n_errors++;
      if (n_errors <= 10) $display("%0t: mismatch: %s", $time, what);
    endfunction

    // Probe from the home slot and apply the request to the shadow table.
    function void note_request(logic op, logic [lph_pkg::KEY_W-1:0] key,
                               logic [lph_pkg::VAL_W-1:0] value);
      int idx;
      int n;
      bit hit;
      reply_t r;
      idx = int'(key % SLOTS);
      hit = 1'b0;
      for (n = 0; n < SLOTS && !hit; n++) begin
        if (!slot_used[idx] || slot_key[idx] == key) hit = 1'b1;
        else idx = (idx + 1) % SLOTS;
      end
      r.value = '0;
      if (!hit) begin
        r.status = lph_pkg::ST_FULL;
      end else if (op == lph_pkg::REQ_INSERT) begin
        slot_used[idx]  = 1'b1;
        slot_key[idx]   = key;
        slot_value[idx] = value;
        r.status = lph_pkg::ST_OK;
      end else if (slot_used[idx]) begin
        r.status = lph_pkg::ST_OK;
        r.value  = slot_value[idx];
      end else begin
        r.status = lph_pkg::ST_NOT_FOUND;
      end
      if (op == lph_pkg::REQ_INSERT) n_inserts++;
      else n_lookups++;
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [lph_pkg::ST_W-1:0] status,
                              logic [lph_pkg::VAL_W-1:0] value);
      reply_t exp_r;
      if (replies_due.size() == 0) begin
        report_error($sformatf("result with nothing pending: status %0d value %h",
                               status, value));
        return;
      end
      exp_r = replies_due.pop_front();
      if (status !== exp_r.status)
        report_error($sformatf("status expected %0d got %0d", exp_r.status, status));
      if (value !== exp_r.value)
        report_error($sformatf("found_value expected %h got %h", exp_r.value, value));
      case (exp_r.status)
        lph_pkg::ST_OK:        n_ok++;
        lph_pkg::ST_NOT_FOUND: n_not_found++;
        default:               n_full++;
      endcase
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function int occupancy();
      int cnt;
      cnt = 0;
      foreach (slot_used[i]) if (slot_used[i]) cnt++;
      return cnt;
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_req_type;
  logic [KEY_W-1:0]        in_req_key;
  logic signed [VAL_W-1:0] in_req_value;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_found_value;

  lph_scoreboard #(TABLE_SLOTS) sb;
  logic [KEY_W-1:0] key_pool[$];
  int burst_left = 0;
  int stall_mode = 0;
  int stall_phase_left = 0;
  int stall_run_left = 0;

  linear_probe_hash_table_unit #(.TABLE_SLOTS(TABLE_SLOTS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_req_key(in_req_key),
    .in_req_value(in_req_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_found_value(out_found_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: switches between no stall, light, heavy and long-run stall patterns.
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase_left <= $urandom_range(64, 256);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_run_left == 0) begin
          out_stall <= !out_stall;
          stall_run_left <= out_stall ? $urandom_range(0, 4) : $urandom_range(0, 20);
        end else begin
          stall_run_left <= stall_run_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_reply(out_status, out_found_value);
      if (in_valid && !in_stall) sb.note_request(in_req_type, in_req_key, in_req_value);
    end
  end

  // Sender works in bursts; a random gap, possibly none, is taken before a new burst starts.
  task automatic send_req(input logic op, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_req_type  <= op;
    in_req_key   <= key;
    in_req_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Half the keys land in a cluster around the wrap point to build long probe chains.
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [6:0] home;
    home = $urandom_range(0, 1) ? 7'(($urandom_range(0, 15) + 120) % 128)
                                : 7'($urandom_range(0, 127));
    return {24'($urandom), home};
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int n_items, input int pool_cap, input int insert_pct);
    int i;
    int roll;
    logic [KEY_W-1:0] key;
    for (i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        if (key_pool.size() < pool_cap && $urandom_range(0, 1)) begin
          key = fresh_key();
          key_pool.push_back(key);
        end else begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        send_req(REQ_INSERT, key, pick_value());
      end else if (roll < insert_pct + (100 - insert_pct) * 2 / 3) begin
        send_req(REQ_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)], $urandom);
      end else begin
        key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : fresh_key();
        send_req(REQ_LOOKUP, key, $urandom);
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("** linear_probe_hash_table_unit: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    in_valid     <= 1'b0;
    in_req_type  <= REQ_LOOKUP;
    in_req_key   <= '0;
    in_req_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, key extremes, wrap past the last slot, collisions, overwrite.
    send_req(REQ_LOOKUP, 31'd0, 32'h0);
    send_req(REQ_INSERT, 31'd0, 32'h8000_0000);
    send_req(REQ_LOOKUP, 31'd0, 32'h0);
    send_req(REQ_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, 31'd255, 32'hFFFF_FFFF);
    send_req(REQ_LOOKUP, 31'd255, 32'h0);
    send_req(REQ_LOOKUP, 31'd383, 32'h0);
    send_req(REQ_INSERT, 31'd0, 32'h0);
    send_req(REQ_LOOKUP, 31'd0, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 31'd5, 32'h5555_5555);
    send_req(REQ_INSERT, 31'd133, 32'hAAAA_AAAA);
    send_req(REQ_INSERT, 31'd261, 32'h0000_0001);
    send_req(REQ_LOOKUP, 31'd261, 32'h0);
    send_req(REQ_LOOKUP, 31'd133, 32'h0);
    send_req(REQ_LOOKUP, 31'd389, 32'h0);
    send_req(REQ_INSERT, 31'd133, 32'h7FFF_FFFF);
    send_req(REQ_LOOKUP, 31'd133, 32'h0);
    send_req(REQ_LOOKUP, 31'h7FFF_FFFF, 32'h0);
    send_req(REQ_LOOKUP, 31'd5, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 31'h4000_0000, 32'h1234_5678);
    send_req(REQ_LOOKUP, 31'h4000_0000, 32'h0);
    key_pool = '{31'd0, 31'h7FFF_FFFF, 31'd255, 31'd5, 31'd133, 31'd261, 31'h4000_0000};
    wait_idle(2);

    // Moderate load, then fill to capacity, then keep hammering the full table.
    run_random(900, 60, 40);
    wait_idle(2);
    run_random(400, 220, 60);
    wait_idle(2);
    run_random(550, 400, 35);
    wait_idle(TABLE_SLOTS + 8);

    $display("requests: %0d inserts, %0d lookups; table ended with %0d of %0d slots used",
             sb.n_inserts, sb.n_lookups, sb.occupancy(), TABLE_SLOTS);
    $display("results: %0d done/found, %0d not found, %0d table full, %0d mismatches",
             sb.n_ok, sb.n_not_found, sb.n_full, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("** linear_probe_hash_table_unit: PASSED **");
    end else begin
      $display("** linear_probe_hash_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
